>>> sv/mspi_pkg.sv
// Shared types and constants for the motor speed PI lock controller.
// Used by mspi_cfg, mspi_core and the top level; depends on nothing.
package mspi_pkg;

  // Integral scaling and drive ceiling.
  localparam int INTEGRAL_SHIFT = 5;
  localparam logic [7:0] DUTY_MAX = 8'd255;

  // Rounding bias that makes the arithmetic shift truncate toward zero.
  localparam logic signed [15:0] DIV_BIAS = 16'((1 << INTEGRAL_SHIFT) - 1);

  // Event codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_CAPTURE = 2'd0,
    OP_TIMEOUT = 2'd1,
    OP_TICK    = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_TARGET_PERIOD  = 3'd0,
    REG_MIN_PERIOD     = 3'd1,
    REG_MAX_PERIOD     = 3'd2,
    REG_LOCK_WINDOW    = 3'd3,
    REG_LOCK_TICKS     = 3'd4,
    REG_INTEGRAL_LIMIT = 3'd5
  } reg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [13:0] TARGET_PERIOD_RST  = 14'd8000;
  localparam logic [15:0] MIN_PERIOD_RST     = 16'd1000;
  localparam logic [13:0] MAX_PERIOD_RST     = 14'd10000;
  localparam logic [9:0]  LOCK_WINDOW_RST    = 10'd40;
  localparam logic [11:0] LOCK_TICKS_RST     = 12'd2000;
  localparam logic [13:0] INTEGRAL_LIMIT_RST = 14'd8192;

  typedef struct packed {
    logic [13:0] target_period;
    logic [15:0] min_period;
    logic [13:0] max_period;
    logic [9:0]  lock_window;
    logic [11:0] lock_ticks;
    logic [13:0] integral_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] capture_time;
    logic        enable_n;
  } item_t;

  typedef struct packed {
    logic [7:0] pwm_duty;
    logic       locked;
    logic       in_window;
  } result_t;

endpackage

>>> sv/mspi_cfg.sv
// Configuration register file for the motor speed PI lock controller.
// Depends on mspi_pkg for the register indexes and the cfg_t struct.
module mspi_cfg
  import mspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_period  <= TARGET_PERIOD_RST;
      cfg.min_period     <= MIN_PERIOD_RST;
      cfg.max_period     <= MAX_PERIOD_RST;
      cfg.lock_window    <= LOCK_WINDOW_RST;
      cfg.lock_ticks     <= LOCK_TICKS_RST;
      cfg.integral_limit <= INTEGRAL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TARGET_PERIOD:  cfg.target_period  <= cfg_data[13:0];
        REG_MIN_PERIOD:     cfg.min_period     <= cfg_data;
        REG_MAX_PERIOD:     cfg.max_period     <= cfg_data[13:0];
        REG_LOCK_WINDOW:    cfg.lock_window    <= cfg_data[9:0];
        REG_LOCK_TICKS:     cfg.lock_ticks     <= cfg_data[11:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/mspi_core.sv
// Controller state and its single-pass update: period capture, PI drive
// and lock counting. Depends on mspi_pkg for item, result and cfg types.
module mspi_core
  import mspi_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result_next
);

  logic [15:0]        last_capture;
  logic               timeout_flag;
  logic signed [14:0] error_integral;
  logic [7:0]         drive_value;
  logic               window_flag;
  logic               run_enabled;
  logic [11:0]        good_tick_count;
  logic               lock_state;

  logic [15:0]        last_capture_next;
  logic               timeout_flag_next;
  logic signed [14:0] error_integral_next;
  logic [7:0]         drive_value_next;
  logic               window_flag_next;
  logic               run_enabled_next;
  logic [11:0]        good_tick_count_next;
  logic               lock_state_next;

  logic [15:0]        period;
  logic [13:0]        period_clamped;
  logic signed [15:0] err;
  logic [15:0]        err_mag;
  logic signed [16:0] integ_sum;
  logic signed [16:0] integ_lim;
  logic signed [14:0] integ_sat;
  logic signed [15:0] integ_wide;
  logic signed [15:0] integ_quot;
  logic signed [15:0] drive_raw;
  logic [7:0]         drive_clamped;
  logic [12:0]        tick_inc;

  // Capture datapath: period, error, saturated integral and drive.
  always_comb begin
    period         = item.capture_time - last_capture;
    period_clamped = (period > {2'b00, cfg.max_period}) ? cfg.max_period : period[13:0];
    err            = $signed({2'b00, period_clamped}) - $signed({2'b00, cfg.target_period});
    err_mag        = (err < 0) ? 16'(-err) : 16'(err);

    integ_sum = 17'(error_integral) + 17'(err);
    integ_lim = $signed({3'b000, cfg.integral_limit});
    if (integ_sum > integ_lim) begin
      integ_sat = 15'(integ_lim);
    end else if (integ_sum < -integ_lim) begin
      integ_sat = 15'(-integ_lim);
    end else begin
      integ_sat = 15'(integ_sum);
    end

    // Division truncating toward zero: bias negative values before the shift.
    integ_wide = 16'(integ_sat);
    integ_quot = (integ_wide < 0) ? ((integ_wide + DIV_BIAS) >>> INTEGRAL_SHIFT)
                                  : (integ_wide >>> INTEGRAL_SHIFT);
    drive_raw  = err + integ_quot;
    if (drive_raw < 0) begin
      drive_clamped = 8'd0;
    end else if (drive_raw > $signed({8'd0, DUTY_MAX})) begin
      drive_clamped = DUTY_MAX;
    end else begin
      drive_clamped = drive_raw[7:0];
    end

    tick_inc = {1'b0, good_tick_count} + 13'd1;
  end

  // Next state for the event in hand.
  always_comb begin
    last_capture_next    = last_capture;
    timeout_flag_next    = timeout_flag;
    error_integral_next  = error_integral;
    drive_value_next     = drive_value;
    window_flag_next     = window_flag;
    run_enabled_next     = run_enabled;
    good_tick_count_next = good_tick_count;
    lock_state_next      = lock_state;

    unique case (op_t'(item.operation))
      OP_CAPTURE: begin
        if (period >= cfg.min_period) begin
          last_capture_next = item.capture_time;
          window_flag_next  = 1'b0;
          if (timeout_flag) begin
            // First capture after a timeout only re-arms the measurement.
            timeout_flag_next = 1'b0;
          end else begin
            window_flag_next    = err_mag < {6'd0, cfg.lock_window};
            error_integral_next = integ_sat;
            if (run_enabled) begin
              drive_value_next = drive_clamped;
            end
          end
        end
      end
      OP_TIMEOUT: begin
        timeout_flag_next = 1'b1;
        if (run_enabled) begin
          drive_value_next = DUTY_MAX;
        end
      end
      OP_TICK: begin
        if (window_flag) begin
          if (tick_inc > {1'b0, cfg.lock_ticks}) begin
            good_tick_count_next = cfg.lock_ticks;
            lock_state_next      = 1'b1;
          end else begin
            good_tick_count_next = tick_inc[11:0];
          end
        end else begin
          good_tick_count_next = 12'd0;
          lock_state_next      = 1'b0;
        end
        run_enabled_next = !item.enable_n;
        if (item.enable_n) begin
          drive_value_next     = 8'd0;
          good_tick_count_next = 12'd0;
        end
      end
      default: ;
    endcase
  end

  // Result as seen after the event.
  assign result_next.pwm_duty  = drive_value_next;
  assign result_next.locked    = run_enabled_next && lock_state_next;
  assign result_next.in_window = window_flag_next;

  // State registers advance once per request.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_capture    <= '0;
      timeout_flag    <= 1'b0;
      error_integral  <= '0;
      drive_value     <= '0;
      window_flag     <= 1'b0;
      run_enabled     <= 1'b0;
      good_tick_count <= '0;
      lock_state      <= 1'b0;
    end else if (step) begin
      last_capture    <= last_capture_next;
      timeout_flag    <= timeout_flag_next;
      error_integral  <= error_integral_next;
      drive_value     <= drive_value_next;
      window_flag     <= window_flag_next;
      run_enabled     <= run_enabled_next;
      good_tick_count <= good_tick_count_next;
      lock_state      <= lock_state_next;
    end
  end

endmodule

>>> sv/motor_speed_pi_lock_controller.sv
// Top level of the motor speed PI lock controller: input and result registers.
// Depends on mspi_pkg, mspi_cfg and mspi_core.
//
// Usage:
// A request on the input channel (in_valid, in_stall) carries one event:
// capture edge with a timer value, capture timeout, or 100 us control tick
// with the active-low enable pin. Every request produces exactly one result
// on the output channel (out_valid, out_stall): the drive duty, the lock pin
// and the in-window flag as they stand after the event.
// A request is taken when valid is high and stall is low on its channel.
// A request passes the input register, then the result register. Throughput
// is one request per cycle unless the receiver stalls; the state update is
// one pass of logic between the input register and the result register.
// When the receiver stalls, the result is held and the input register can
// still take one more request; after that in_stall rises until the result
// is taken.
// Configuration registers are written on the cfg channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data), which is always ready; writes to an
// unknown index are dropped.
// Reset (rst, synchronous) clears all state, empties both registers and
// loads the default configuration.
module motor_speed_pi_lock_controller
  import mspi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] capture_time,
  input  logic        enable_n,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  pwm_duty,
  output logic        locked,
  output logic        in_window,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t result_next;
  result_t result;

  mspi_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held request moves on unless a result is stuck at the output.
  assign advance  = item_valid && !(out_valid && out_stall);
  assign in_stall = item_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item.operation    <= operation;
      item.capture_time <= capture_time;
      item.enable_n     <= enable_n;
    end
  end

  mspi_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (item),
    .cfg         (cfg),
    .result_next (result_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign pwm_duty  = result.pwm_duty;
  assign locked    = result.locked;
  assign in_window = result.in_window;

  // A request moved on always shows up as a result in the next cycle.
  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("request advanced without a result");

  // Back-pressure only while a request is held behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (item_valid && out_valid && out_stall))
    else $error("input stalled without cause");

  // A tick with the motor disabled leaves no drive and no lock.
  a_disable_tick: assert property (@(posedge clk) disable iff (rst)
    (advance && item.operation == OP_TICK && item.enable_n) |=>
      (pwm_duty == 8'd0 && !locked))
    else $error("disabled tick left drive or lock active");

endmodule
